[rtl/jsu_pkg.sv]
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and constants of the JSON string unescaper
// Decode modes, character codes, UTF-8 limits and the result bundle types.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESCAPE = 3'd1,
    MODE_HEX    = 3'd2
  } mode_t;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;

  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_BS        = 8'h08;
  localparam logic [7:0] CH_FF        = 8'h0C;

  localparam logic [15:0] UTF8_ONE_LIMIT = 16'h0080;
  localparam logic [15:0] UTF8_TWO_LIMIT = 16'h0800;
  localparam logic [7:0]  UTF8_CONT      = 8'h80;
  localparam logic [7:0]  UTF8_LEAD2     = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3     = 8'hE0;
  localparam logic [7:0]  UTF8_LOW6      = 8'h3F;

  localparam int MAX_RESULTS = 3;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       bad;
    logic       eos;
  } res_t;

  typedef struct packed {
    logic [1:0]                   count;
    res_t [MAX_RESULTS-1:0]       res;
  } bundle_t;

  typedef struct packed {
    mode_t       mode;
    logic [23:0] held;
    logic [1:0]  count;
  } dec_state_t;

endpackage

`default_nettype wire

[rtl/jsu_decode.sv]
// ----------------------------------------------------------------------------
// jsu_decode: per-byte decode logic
// Turns one input byte and the current decode state into up to three
// result items and the next decode state.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_decode (
  input  wire logic [7:0]         in_byte,
  input  wire logic               last_byte,
  input  wire jsu_pkg::dec_state_t state,
  output jsu_pkg::dec_state_t     state_nxt,
  output jsu_pkg::bundle_t        bundle
);

  function automatic logic [7:0] map_escape(input logic [7:0] ch);
    logic [7:0] m;
    case (ch)
      jsu_pkg::CH_N: m = jsu_pkg::CH_LF;
      jsu_pkg::CH_T: m = jsu_pkg::CH_TAB;
      jsu_pkg::CH_R: m = jsu_pkg::CH_CR;
      jsu_pkg::CH_B: m = jsu_pkg::CH_BS;
      jsu_pkg::CH_F: m = jsu_pkg::CH_FF;
      default:       m = ch;
    endcase
    return m;
  endfunction

  // {is_digit, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] ch);
    logic [4:0] h;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      h = {1'b1, ch[3:0]};
    end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
      h = {1'b1, 4'(ch[3:0] + 4'd9)};
    end else begin
      h = 5'd0;
    end
    return h;
  endfunction

  always_comb begin
    logic [1:0]  n;
    logic [7:0]  chars [4];
    logic [15:0] cp;
    logic        stop;
    logic        any_digit;
    logic        esc;
    logic [4:0]  hd;

    state_nxt    = state;
    bundle       = '0;
    n            = 2'd0;
    cp           = 16'd0;
    stop         = 1'b0;
    any_digit    = 1'b0;
    esc          = 1'b0;
    hd           = 5'd0;
    chars[0]     = 8'd0;
    chars[1]     = 8'd0;
    chars[2]     = 8'd0;
    chars[3]     = 8'd0;

    case (state.mode)
      jsu_pkg::MODE_ESCAPE: begin
        if (in_byte == jsu_pkg::CH_U) begin
          state_nxt.mode  = jsu_pkg::MODE_HEX;
          state_nxt.held  = 24'd0;
          state_nxt.count = 2'd0;
        end else begin
          bundle.res[n] = '{data: map_escape(in_byte), valid: 1'b1, bad: 1'b0, eos: 1'b0};
          n = n + 2'd1;
          state_nxt.mode = jsu_pkg::MODE_NORMAL;
        end
      end
      jsu_pkg::MODE_HEX: begin
        if (state.count == 2'd3) begin
          chars[0] = state.held[23:16];
          chars[1] = state.held[15:8];
          chars[2] = state.held[7:0];
          chars[3] = in_byte;
          for (int k = 0; k < 4; k++) begin
            hd = hex_digit(chars[k]);
            if (!stop) begin
              if (hd[4]) begin
                cp        = {cp[11:0], hd[3:0]};
                any_digit = 1'b1;
              end else begin
                stop = 1'b1;
              end
            end
          end
          if (!any_digit) begin
            bundle.res[n] = '{data: 8'd0, valid: 1'b0, bad: 1'b1, eos: 1'b0};
            n = n + 2'd1;
          end else if (cp < jsu_pkg::UTF8_ONE_LIMIT) begin
            bundle.res[n] = '{data: cp[7:0], valid: 1'b1, bad: 1'b0, eos: 1'b0};
            n = n + 2'd1;
          end else if (cp < jsu_pkg::UTF8_TWO_LIMIT) begin
            bundle.res[n] = '{data: jsu_pkg::UTF8_LEAD2 | {3'd0, cp[10:6]},
                              valid: 1'b1, bad: 1'b0, eos: 1'b0};
            n = n + 2'd1;
            bundle.res[n] = '{data: jsu_pkg::UTF8_CONT | (cp[7:0] & jsu_pkg::UTF8_LOW6),
                              valid: 1'b1, bad: 1'b0, eos: 1'b0};
            n = n + 2'd1;
          end else begin
            bundle.res[n] = '{data: jsu_pkg::UTF8_LEAD3 | {4'd0, cp[15:12]},
                              valid: 1'b1, bad: 1'b0, eos: 1'b0};
            n = n + 2'd1;
            bundle.res[n] = '{data: jsu_pkg::UTF8_CONT | (cp[13:6] & jsu_pkg::UTF8_LOW6),
                              valid: 1'b1, bad: 1'b0, eos: 1'b0};
            n = n + 2'd1;
            bundle.res[n] = '{data: jsu_pkg::UTF8_CONT | (cp[7:0] & jsu_pkg::UTF8_LOW6),
                              valid: 1'b1, bad: 1'b0, eos: 1'b0};
            n = n + 2'd1;
          end
          state_nxt.mode  = jsu_pkg::MODE_NORMAL;
          state_nxt.held  = 24'd0;
          state_nxt.count = 2'd0;
        end else if (last_byte) begin
          // string ended inside the escape: drop it, decode held chars again
          case (state.count)
            2'd0: begin
              chars[0] = in_byte;
            end
            2'd1: begin
              chars[0] = state.held[7:0];
              chars[1] = in_byte;
            end
            default: begin
              chars[0] = state.held[15:8];
              chars[1] = state.held[7:0];
              chars[2] = in_byte;
            end
          endcase
          for (int k = 0; k < 3; k++) begin
            if ({1'b0, state.count} >= 3'(k)) begin
              if (esc) begin
                esc = 1'b0;
                if (chars[k] != jsu_pkg::CH_U) begin
                  bundle.res[n] = '{data: map_escape(chars[k]), valid: 1'b1,
                                    bad: 1'b0, eos: 1'b0};
                  n = n + 2'd1;
                end
              end else if (chars[k] == jsu_pkg::CH_BACKSLASH) begin
                esc = 1'b1;
              end else begin
                bundle.res[n] = '{data: chars[k], valid: 1'b1, bad: 1'b0, eos: 1'b0};
                n = n + 2'd1;
              end
            end
          end
        end else begin
          state_nxt.held  = {state.held[15:0], in_byte};
          state_nxt.count = state.count + 2'd1;
        end
      end
      default: begin
        if (in_byte == jsu_pkg::CH_BACKSLASH) begin
          state_nxt.mode = jsu_pkg::MODE_ESCAPE;
        end else begin
          bundle.res[n] = '{data: in_byte, valid: 1'b1, bad: 1'b0, eos: 1'b0};
          n = n + 2'd1;
          state_nxt.mode = jsu_pkg::MODE_NORMAL;
        end
      end
    endcase

    if (last_byte) begin
      if (n == 2'd0) begin
        bundle.res[n] = '{data: 8'd0, valid: 1'b0, bad: 1'b0, eos: 1'b0};
        n = n + 2'd1;
      end
      bundle.res[n - 2'd1].eos = 1'b1;
      state_nxt.mode  = jsu_pkg::MODE_NORMAL;
      state_nxt.held  = 24'd0;
      state_nxt.count = 2'd0;
    end

    bundle.count = n;
  end

endmodule

`default_nettype wire

[rtl/jsu_outbuf.sv]
// ----------------------------------------------------------------------------
// jsu_outbuf: result register and serializer
// Holds the results of one input byte and hands them out one per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_outbuf (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire jsu_pkg::bundle_t bundle,
  input  wire logic             pop_ready,
  output logic                  pop_valid,
  output jsu_pkg::res_t         head,
  output logic                  space
);

  jsu_pkg::res_t [jsu_pkg::MAX_RESULTS-1:0] buf_r;
  logic [1:0]                               cnt_r;
  logic                                     pop;

  assign pop_valid = (cnt_r != 2'd0);
  assign pop       = pop_valid && pop_ready;
  assign head      = buf_r[0];
  // free once the last held result leaves in this cycle
  assign space     = (cnt_r == 2'd0) || (cnt_r == 2'd1 && pop_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load) begin
      cnt_r <= bundle.count;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= bundle.res;
    end else if (pop) begin
      buf_r <= {jsu_pkg::res_t'('0), buf_r[jsu_pkg::MAX_RESULTS-1:1]};
    end
  end

endmodule

`default_nettype wire

[rtl/json_string_unescape_core.sv]
// ----------------------------------------------------------------------------
// json_string_unescape_core: streaming JSON string body unescaper
// Decodes backslash escapes, including backslash-u to UTF-8, one byte a beat.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata        | tuser                       | tlast
//  --------+-----------+--------------+-----------------------------+--------------
//  in_     | slave     | in_byte[7:0] | -                           | last_byte
//  out_    | master    | out_byte[7:0]| [0] out_valid [1] bad_escape| end_of_string
//
//  Flow: an input byte is decoded in the cycle it is accepted and its
//  results sit in the result register on the next cycle. A byte with more than
//  one result holds in_tready low until its last result is leaving, while the
//  result register drains one beat per cycle whenever out_tready is high.
//  Reset: synchronous on rst_n low; decode state returns to normal text and
//  the result register empties.
//  Stalls: out_tready low holds the current result; a new byte is taken as
//  soon as the last held result leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       in_tlast,   // last_byte
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic [1:0]      out_tuser,  // [0] out_valid, [1] bad_escape
  output logic            out_tlast   // end_of_string
);

  jsu_pkg::dec_state_t state_r;
  jsu_pkg::dec_state_t state_nxt;
  jsu_pkg::bundle_t    bundle;
  jsu_pkg::res_t       head;
  logic                in_beat;
  logic                space;

  assign in_tready = space;
  assign in_beat   = in_tvalid && in_tready;

  // decode the incoming beat against the current escape state
  jsu_decode u_decode (
    .in_byte   (in_tdata),
    .last_byte (in_tlast),
    .state     (state_r),
    .state_nxt (state_nxt),
    .bundle    (bundle)
  );

  // advance escape state only on an accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode  <= jsu_pkg::MODE_NORMAL;
      state_r.held  <= 24'd0;
      state_r.count <= 2'd0;
    end else if (in_beat) begin
      state_r <= state_nxt;
    end
  end

  // hold the results of one byte and drain them one beat at a time
  jsu_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_beat),
    .bundle    (bundle),
    .pop_ready (out_tready),
    .pop_valid (out_tvalid),
    .head      (head),
    .space     (space)
  );

  assign out_tdata = head.data;
  assign out_tuser = {head.bad, head.valid};
  assign out_tlast = head.eos;

endmodule

`default_nettype wire

[rtl/jsu_checker.sv]
// ----------------------------------------------------------------------------
// jsu_checker: port-level assertions for the unescaper
// Watches the stream ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic       in_tlast,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic [1:0] out_tuser,
  input wire logic       out_tlast
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // input is held off only while results wait
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty result register");

  // the last byte of a string always yields a result
  a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> out_tvalid)
    else $error("no result after last byte");

  // a bad escape carries no byte
  a_bad_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> !out_tuser[0] && out_tdata == 8'd0)
    else $error("bad escape result carries data");

  // an empty result without error only closes a string
  a_empty_eos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] && !out_tuser[1] |-> out_tlast && out_tdata == 8'd0)
    else $error("empty result not at end of string");

endmodule

bind json_string_unescape_core jsu_checker u_jsu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for json_string_unescape_core
// Feeds JSON string bodies into the input stream, one byte a beat, and checks
// every decoded beat against an in-bench model of the unescaper or the result
// written in a row of a short directed table that covers the corners; random
// strings of plain bytes, simple escapes, unicode escapes, broken escapes and
// noise follow. Both sides idle in random bursts; the run's tail is full rate.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  // one input beat; rows with has_want carry a hand-written expected result
  typedef struct packed {
    logic [7:0]    ch;
    logic          is_last;
    logic          has_want;
    jsu_pkg::res_t want;
  } feed_t;

  localparam int DIR_ROWS   = 24;
  localparam int RAND_ITEMS = 300;
  localparam int CALM_TAIL  = 60;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic [1:0] out_tuser;
  logic       out_tlast;

  feed_t         feed_q[$];
  jsu_pkg::res_t expected_q[$];
  jsu_pkg::res_t step_out[$];
  int            taken;
  int            err_count;
  bit            gaps_on;

  // decoder state of the model
  jsu_pkg::mode_t dec_mode;
  logic [23:0]    esc_held;
  logic [1:0]     esc_count;

  // directed corners: extremes, escapes, bad unicode escape, early ends
  feed_t dir_rows [DIR_ROWS] = '{
    {8'h41,                 1'b0, 1'b1, 8'h41,  1'b1, 1'b0, 1'b0},  // plain 'A'
    {8'h00,                 1'b0, 1'b1, 8'h00,  1'b1, 1'b0, 1'b0},  // lowest byte
    {8'hFF,                 1'b1, 1'b1, 8'hFF,  1'b1, 1'b0, 1'b1},  // highest, ends
    {jsu_pkg::CH_BACKSLASH, 1'b0, 1'b0, 11'h0},
    {jsu_pkg::CH_N,         1'b0, 1'b1, jsu_pkg::CH_LF, 1'b1, 1'b0, 1'b0},  // \n -> LF
    {jsu_pkg::CH_BACKSLASH, 1'b0, 1'b0, 11'h0},
    {jsu_pkg::CH_T,         1'b0, 1'b0, 11'h0},                     // \t
    {jsu_pkg::CH_BACKSLASH, 1'b0, 1'b0, 11'h0},
    {jsu_pkg::CH_U,         1'b0, 1'b0, 11'h0},
    {8'h46,                 1'b0, 1'b0, 11'h0},                     // 'F'
    {8'h66,                 1'b0, 1'b0, 11'h0},                     // 'f'
    {8'h46,                 1'b0, 1'b0, 11'h0},
    {8'h46,                 1'b0, 1'b0, 11'h0},                     // U+FFFF, three bytes
    {jsu_pkg::CH_BACKSLASH, 1'b0, 1'b0, 11'h0},
    {jsu_pkg::CH_U,         1'b0, 1'b0, 11'h0},
    {8'h7A,                 1'b0, 1'b0, 11'h0},                     // 'z', no hex digit
    {8'h7A,                 1'b0, 1'b0, 11'h0},
    {8'h7A,                 1'b0, 1'b0, 11'h0},
    {8'h7A,                 1'b0, 1'b1, 8'h00,  1'b0, 1'b1, 1'b0},  // bad unicode escape
    {jsu_pkg::CH_BACKSLASH, 1'b1, 1'b1, 8'h00,  1'b0, 1'b0, 1'b1},  // lone backslash at end
    {jsu_pkg::CH_BACKSLASH, 1'b0, 1'b0, 11'h0},
    {jsu_pkg::CH_U,         1'b0, 1'b0, 11'h0},
    {jsu_pkg::CH_BACKSLASH, 1'b0, 1'b0, 11'h0},
    {jsu_pkg::CH_R,         1'b1, 1'b0, 11'h0}                      // end inside \u: replay "\r"
  };

  json_string_unescape_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] in_byte
    .in_tlast   (in_tlast),    // last_byte
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [7:0] out_byte
    .out_tuser  (out_tuser),   // [0] out_valid, [1] bad_escape
    .out_tlast  (out_tlast)    // end_of_string
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up well past the slowest legal run.
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------- model

  function automatic logic [7:0] esc_char(input logic [7:0] c);
    case (c)
      jsu_pkg::CH_N: return jsu_pkg::CH_LF;
      jsu_pkg::CH_T: return jsu_pkg::CH_TAB;
      jsu_pkg::CH_R: return jsu_pkg::CH_CR;
      jsu_pkg::CH_B: return jsu_pkg::CH_BS;
      jsu_pkg::CH_F: return jsu_pkg::CH_FF;
      default:       return c;
    endcase
  endfunction

  // value of a hex digit, -1 for anything else
  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  task automatic push_char(input logic [7:0] data, input logic valid, input logic bad);
    jsu_pkg::res_t r;
    r = '{data: data, valid: valid, bad: bad, eos: 1'b0};
    step_out.insert(step_out.size(), r);
  endtask

  task automatic push_utf8(input logic [15:0] cp);
    if (cp < jsu_pkg::UTF8_ONE_LIMIT) begin
      push_char(cp[7:0], 1'b1, 1'b0);
    end else if (cp < jsu_pkg::UTF8_TWO_LIMIT) begin
      push_char(jsu_pkg::UTF8_LEAD2 | {3'b0, cp[10:6]}, 1'b1, 1'b0);
      push_char(jsu_pkg::UTF8_CONT | (cp[7:0] & jsu_pkg::UTF8_LOW6), 1'b1, 1'b0);
    end else begin
      push_char(jsu_pkg::UTF8_LEAD3 | {4'b0, cp[15:12]}, 1'b1, 1'b0);
      push_char(jsu_pkg::UTF8_CONT | ({2'b0, cp[11:6]}), 1'b1, 1'b0);
      push_char(jsu_pkg::UTF8_CONT | (cp[7:0] & jsu_pkg::UTF8_LOW6), 1'b1, 1'b0);
    end
  endtask

  // Decode one accepted byte into step_out and advance the model state.
  task automatic unescape_byte(input logic [7:0] c, input logic is_last);
    logic [7:0]  chars [4];
    logic [15:0] cp;
    int          digits;
    int          nib;
    int          total;
    bit          stop;
    bit          esc;
    case (dec_mode)
      jsu_pkg::MODE_ESCAPE: begin
        if (c == jsu_pkg::CH_U) begin
          dec_mode  = jsu_pkg::MODE_HEX;
          esc_held  = '0;
          esc_count = '0;
        end else begin
          push_char(esc_char(c), 1'b1, 1'b0);
          dec_mode = jsu_pkg::MODE_NORMAL;
        end
      end
      jsu_pkg::MODE_HEX: begin
        if (esc_count == 2'd3) begin
          chars[0] = esc_held[23:16];
          chars[1] = esc_held[15:8];
          chars[2] = esc_held[7:0];
          chars[3] = c;
          cp     = '0;
          digits = 0;
          stop   = 1'b0;
          for (int k = 0; k < 4; k++) begin
            nib = hex_nibble(chars[k]);
            if (nib < 0) stop = 1'b1;
            if (!stop) begin
              cp = {cp[11:0], 4'(nib)};
              digits++;
            end
          end
          if (digits == 0) push_char(8'h00, 1'b0, 1'b1);
          else push_utf8(cp);
          dec_mode  = jsu_pkg::MODE_NORMAL;
          esc_held  = '0;
          esc_count = '0;
        end else if (is_last) begin
          // string ended early: drop the \u and replay what was held
          total = int'(esc_count) + 1;
          for (int k = 0; k < int'(esc_count); k++)
            chars[k] = esc_held[8*(int'(esc_count)-1-k) +: 8];
          chars[esc_count] = c;
          esc = 1'b0;
          for (int k = 0; k < total; k++) begin
            if (esc) begin
              esc = 1'b0;
              if (chars[k] != jsu_pkg::CH_U) push_char(esc_char(chars[k]), 1'b1, 1'b0);
            end else if (chars[k] == jsu_pkg::CH_BACKSLASH) begin
              esc = 1'b1;
            end else begin
              push_char(chars[k], 1'b1, 1'b0);
            end
          end
        end else begin
          esc_held  = {esc_held[15:0], c};
          esc_count = esc_count + 2'd1;
        end
      end
      default: begin
        if (c == jsu_pkg::CH_BACKSLASH) dec_mode = jsu_pkg::MODE_ESCAPE;
        else begin
          push_char(c, 1'b1, 1'b0);
          dec_mode = jsu_pkg::MODE_NORMAL;
        end
      end
    endcase

    if (is_last) begin
      if (step_out.size() == 0) push_char(8'h00, 1'b0, 1'b0);
      step_out[step_out.size()-1].eos = 1'b1;
      dec_mode  = jsu_pkg::MODE_NORMAL;
      esc_held  = '0;
      esc_count = '0;
    end
  endtask

  // ------------------------------------------------------------ scoreboard

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      err_count++;
    end
  endtask

  // Retire result beats against the oldest expectation, then predict the
  // results of any input beat taken at this edge.
  always @(posedge clk) begin : scoreboard
    jsu_pkg::res_t want;
    feed_t         item;
    if (!rst_n) begin
      dec_mode  = jsu_pkg::MODE_NORMAL;
      esc_held  = '0;
      esc_count = '0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected: out_byte %0h", out_tdata);
          err_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("out_byte", want.data, out_tdata);
          check_field("out_valid", want.valid, out_tuser[0]);
          check_field("bad_escape", want.bad, out_tuser[1]);
          check_field("end_of_string", want.eos, out_tlast);
        end
      end
      if (in_tvalid && in_tready && taken < feed_q.size()) begin
        item = feed_q[taken];
        taken++;
        step_out.delete();
        unescape_byte(item.ch, item.is_last);
        if (item.has_want) expected_q.insert(expected_q.size(), item.want);
        else foreach (step_out[i]) expected_q.insert(expected_q.size(), step_out[i]);
      end
    end
  end

  // -------------------------------------------------------------- stimulus

  function automatic logic [7:0] pick_hex();
    int idx;
    idx = $urandom_range(0, 21);
    if (idx < 10) return 8'("0" + idx);
    if (idx < 16) return 8'("a" + idx - 10);
    return 8'("A" + idx - 16);
  endfunction

  function automatic logic [7:0] pick_nonhex();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (hex_nibble(b) >= 0) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  task automatic push_feed(input logic [7:0] ch);
    feed_t f;
    f = {ch, 1'b0, 1'b0, 11'h0};
    feed_q.insert(feed_q.size(), f);
  endtask

  // One random string body: mostly well-formed pieces, some noise, and now
  // and then an ending that cuts an escape short.
  task automatic add_string();
    logic [7:0] b;
    int         pieces;
    int         kind;
    int         nd;
    int         tail;
    pieces = $urandom_range(1, 8);
    for (int p = 0; p < pieces; p++) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        b = 8'($urandom_range(0, 255));
        push_feed(b == jsu_pkg::CH_BACKSLASH ? 8'h5B : b);
      end else if (kind < 65) begin
        push_feed(jsu_pkg::CH_BACKSLASH);
        case ($urandom_range(0, 8))
          0: push_feed(jsu_pkg::CH_N);
          1: push_feed(jsu_pkg::CH_T);
          2: push_feed(jsu_pkg::CH_R);
          3: push_feed(jsu_pkg::CH_B);
          4: push_feed(jsu_pkg::CH_F);
          5: push_feed(8'h2F);        // slash
          6: push_feed(8'h22);        // quote
          7: push_feed(jsu_pkg::CH_BACKSLASH);
          default: begin
            b = 8'($urandom_range(0, 255));
            push_feed(b == jsu_pkg::CH_U ? 8'h76 : b);
          end
        endcase
      end else if (kind < 90) begin
        // \u with nd leading hex digits; below four digits a stopper and filler follow
        push_feed(jsu_pkg::CH_BACKSLASH);
        push_feed(jsu_pkg::CH_U);
        nd = $urandom_range(0, 4);
        for (int k = 0; k < 4; k++) begin
          if (k < nd) push_feed(pick_hex());
          else if (k == nd) push_feed(pick_nonhex());
          else push_feed(8'($urandom_range(0, 255)));
        end
      end else begin
        for (int k = $urandom_range(1, 4); k > 0; k--) begin
          if ($urandom_range(0, 2) == 0) push_feed(jsu_pkg::CH_BACKSLASH);
          else push_feed(8'($urandom_range(0, 255)));
        end
      end
    end

    tail = $urandom_range(0, 9);
    if (tail == 0) begin
      push_feed(jsu_pkg::CH_BACKSLASH);
    end else if (tail == 1) begin
      push_feed(jsu_pkg::CH_BACKSLASH);
      push_feed(jsu_pkg::CH_U);
      for (int k = $urandom_range(0, 3); k > 0; k--) begin
        case ($urandom_range(0, 3))
          0: push_feed(jsu_pkg::CH_BACKSLASH);
          1: push_feed(jsu_pkg::CH_U);
          2: push_feed(pick_hex());
          default: push_feed(8'($urandom_range(0, 255)));
        endcase
      end
    end
    feed_q[feed_q.size()-1].is_last = 1'b1;
  endtask

  // Result side: hold tready low in short random bursts while gaps are on.
  initial begin : ready_gen
    int hold;
    hold = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Input side: build the whole byte list, then stream it beat by beat.
  initial begin : feeder
    int n;
    err_count = 0;
    taken     = 0;
    gaps_on   = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'h00;
    in_tlast  <= 1'b0;

    foreach (dir_rows[i]) feed_q.insert(feed_q.size(), dir_rows[i]);
    while (feed_q.size() < DIR_ROWS + RAND_ITEMS) add_string();
    n = feed_q.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < n; i++) begin
      // gaps come in stretches and stop for the tail of the run
      gaps_on = (i < n - CALM_TAIL) && ((i / 50) % 4 != 3);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= feed_q[i].ch;
      in_tlast  <= feed_q[i].is_last;
      do @(posedge clk); while (!in_tready);
    end
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;

    // drain, then leave room for any stray beat to show up
    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
